@@ sv/tcc_pkg.sv @@
package tcc_pkg;

    localparam int TEMP_W   = 14;
    localparam int ADC_W    = 10;
    localparam int THR_W    = 14;
    localparam int SEG_W    = 6;
    localparam int FRAC_W   = 4;
    localparam int TABLE_N  = 65;
    localparam int RING_N   = 4;
    localparam int SUM_W    = 16;
    localparam int WIDE_W   = 16;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [THR_W-1:0]         thr_t;
    typedef logic [ADC_W-1:0]         adc_t;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 14'd20;
    localparam temp_t            ACCEPT_LOW      = -14'sd2000;
    localparam temp_t            ACCEPT_HIGH     = 14'sd5000;

    localparam temp_t TEMP_TABLE [0:TABLE_N-1] = '{
        -14'sd7422, -14'sd3169, -14'sd2009, -14'sd1280, -14'sd737, -14'sd300,
        14'sd70, 14'sd393, 14'sd679, 14'sd939, 14'sd1176, 14'sd1395,
        14'sd1600, 14'sd1792, 14'sd1974, 14'sd2146, 14'sd2310, 14'sd2467,
        14'sd2617, 14'sd2762, 14'sd2902, 14'sd3037, 14'sd3169, 14'sd3296,
        14'sd3420, 14'sd3541, 14'sd3659, 14'sd3775, 14'sd3888, 14'sd3999,
        14'sd4108, 14'sd4215, 14'sd4320, 14'sd4423, 14'sd4526, 14'sd4626,
        14'sd4726, 14'sd4824, 14'sd4921, 14'sd5018, 14'sd5113, 14'sd5207,
        14'sd5301, 14'sd5394, 14'sd5487, 14'sd5578, 14'sd5670, 14'sd5760,
        14'sd5851, 14'sd5941, 14'sd6030, 14'sd6120, 14'sd6209, 14'sd6298,
        14'sd6387, 14'sd6476, 14'sd6565, 14'sd6653, 14'sd6742, 14'sd6831,
        14'sd6920, 14'sd7010, 14'sd7100, 14'sd7189, 14'sd7279
    };

endpackage

@@ sv/tcc_interp.sv @@
module tcc_interp
(
    input  tcc_pkg::adc_t  sample,
    output tcc_pkg::temp_t value
);

    logic [tcc_pkg::SEG_W-1:0]  seg;
    logic [tcc_pkg::SEG_W:0]    seg_hi;
    logic [tcc_pkg::FRAC_W-1:0] frac;
    tcc_pkg::temp_t             lo;
    tcc_pkg::temp_t             hi;
    logic signed [14:0]         diff;
    logic signed [19:0]         prod;
    logic signed [19:0]         prod_adj;
    logic signed [15:0]         step;
    logic signed [15:0]         sum;

    always_comb
    begin
        seg      = sample[tcc_pkg::ADC_W-1:tcc_pkg::FRAC_W];
        frac     = sample[tcc_pkg::FRAC_W-1:0];
        seg_hi   = {1'b0, seg} + 7'd1;
        lo       = tcc_pkg::TEMP_TABLE[{1'b0, seg}];
        hi       = tcc_pkg::TEMP_TABLE[seg_hi];
        diff     = 15'(hi) - 15'(lo);
        prod     = $signed({16'd0, frac}) * 20'(diff);
        // round toward zero on the shift
        prod_adj = prod + (prod[19] ? 20'sd15 : 20'sd0);
        step     = 16'(prod_adj >>> tcc_pkg::FRAC_W);
        sum      = 16'(lo) + step;
        value    = sum[tcc_pkg::TEMP_W-1:0];
    end

endmodule

@@ sv/thermistor_temperature_conditioner.sv @@
// Pipeline: sample transfer -> input register -> result register -> result valid.
// Throughput: one sample per cycle unless result_stall holds the result register; the ring,
// mean and reported level update in the single combinational pass between both registers.
// Reset (rst_n low, asynchronous): ring, position, mean and reported level clear to zero,
// threshold returns to 20, both pipeline registers empty.
module thermistor_temperature_conditioner
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  tcc_pkg::thr_t         change_threshold,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  tcc_pkg::adc_t         adc_sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output tcc_pkg::temp_t        converted_value,
    output logic                  accepted,
    output tcc_pkg::temp_t        mean_temperature,
    output logic                  changed,
    output tcc_pkg::temp_t        reported_level
);

    tcc_pkg::thr_t  thr_reg;
    logic           in_valid_reg;
    tcc_pkg::adc_t  sample_reg;
    logic           res_valid_reg;
    tcc_pkg::temp_t conv_reg;
    logic           acc_reg;
    logic           chg_reg;
    tcc_pkg::temp_t ring_reg [0:tcc_pkg::RING_N-1];
    logic [1:0]     pos_reg;
    tcc_pkg::temp_t mean_reg;
    tcc_pkg::temp_t last_reg;

    tcc_pkg::temp_t ring_next [0:tcc_pkg::RING_N-1];
    tcc_pkg::temp_t mean_next;
    tcc_pkg::temp_t last_next;
    logic           acc_next;
    logic           chg_next;

    tcc_pkg::temp_t                   conv;
    logic signed [tcc_pkg::SUM_W-1:0] sum;
    logic signed [tcc_pkg::SUM_W-1:0] sum_adj;
    logic signed [tcc_pkg::WIDE_W-1:0] lower;
    logic signed [tcc_pkg::WIDE_W-1:0] upper;
    logic signed [tcc_pkg::WIDE_W-1:0] mean_w;
    logic           out_free;
    logic           advance;

    tcc_interp u_interp
    (
        .sample (sample_reg),
        .value  (conv)
    );

    assign cfg_ready    = 1'b1;
    assign out_free     = !res_valid_reg || !result_stall;
    assign advance      = in_valid_reg && out_free;
    assign sample_stall = in_valid_reg && !out_free;

    always_comb
    begin
        acc_next = (conv >= tcc_pkg::ACCEPT_LOW) && (conv <= tcc_pkg::ACCEPT_HIGH);
        for (int i = 0; i < tcc_pkg::RING_N; i++)
        begin
            ring_next[i] = (acc_next && (pos_reg == 2'(i))) ? conv : ring_reg[i];
        end
        sum = 16'(ring_next[0]) + 16'(ring_next[1]) + 16'(ring_next[2]) + 16'(ring_next[3]);
        sum_adj = sum + (sum[tcc_pkg::SUM_W-1] ? 16'sd3 : 16'sd0);
        mean_w  = sum_adj >>> 2;
        lower   = 16'(last_reg) - $signed({2'b00, thr_reg});
        upper   = 16'(last_reg) + $signed({2'b00, thr_reg});
        chg_next  = acc_next && ((lower >= mean_w) || (upper <= mean_w));
        mean_next = acc_next ? mean_w[tcc_pkg::TEMP_W-1:0] : mean_reg;
        last_next = chg_next ? mean_w[tcc_pkg::TEMP_W-1:0] : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= tcc_pkg::THRESHOLD_RESET;
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
            mean_reg      <= '0;
            last_reg      <= '0;
            for (int i = 0; i < tcc_pkg::RING_N; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= change_threshold;
            end
            if (!sample_stall)
            begin
                in_valid_reg <= sample_valid;
            end
            if (out_free)
            begin
                res_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                for (int i = 0; i < tcc_pkg::RING_N; i++)
                begin
                    ring_reg[i] <= ring_next[i];
                end
                if (acc_next)
                begin
                    pos_reg <= pos_reg + 2'd1;
                end
                mean_reg <= mean_next;
                last_reg <= last_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!sample_stall && sample_valid)
        begin
            sample_reg <= adc_sample;
        end
        if (advance)
        begin
            conv_reg <= conv;
            acc_reg  <= acc_next;
            chg_reg  <= chg_next;
        end
    end

    assign result_valid     = res_valid_reg;
    assign converted_value  = conv_reg;
    assign accepted         = acc_reg;
    assign changed          = chg_reg;
    assign mean_temperature = mean_reg;
    assign reported_level   = last_reg;

endmodule
